// File: design/gammatone_biquad_cascade_macros.svh
// Assertion macros shared by the gammatone cascade modules.
// Expects signals named clk and arst_n in the including module.
`ifndef GAMMATONE_BIQUAD_CASCADE_MACROS_SVH
`define GAMMATONE_BIQUAD_CASCADE_MACROS_SVH

// Plain invariant, checked at every clock edge out of reset.
`define GBC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("gammatone cascade: invariant violated");

// Same-cycle implication; the consequent may start with a fixed delay.
`define GBC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gammatone cascade: implication violated");

// Next-cycle implication.
`define GBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gammatone cascade: next-cycle implication violated");

`endif

// File: design/gbc_pkg.sv
// Shared constants, types and arithmetic helpers of the gammatone cascade.
// No dependencies; used by gbc_cell, gbc_scale and the top level.
package gbc_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int STATE_FRAC_BITS = 24;
	localparam int NUM_STAGES      = 4;
	localparam int COEF_W          = 32;
	localparam int COEF_FRAC       = 28;
	localparam int STATE_W         = 64;
	localparam int MAG_W           = 15;
	localparam int S_TDATA_W       = 16;
	localparam int M_TDATA_W       = 16;
	localparam int CFG_IDX_W       = 3;

	// Sample to state format shift, one of the two is zero.
	localparam int TO_STATE_SHL =
		(STATE_FRAC_BITS >= SAMPLE_BITS - 1) ? STATE_FRAC_BITS - (SAMPLE_BITS - 1) : 0;
	localparam int TO_STATE_SHR =
		(STATE_FRAC_BITS >= SAMPLE_BITS - 1) ? 0 : (SAMPLE_BITS - 1) - STATE_FRAC_BITS;

	localparam logic [2:0] MUL_STEPS  = 3'd6;   // three products, low and high half each
	localparam logic [1:0] WARMUP_LEN = 2'd2;
	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM1_ONE   = 3'd0,
		REG_NUM1_TWO   = 3'd1,
		REG_NUM1_THREE = 3'd2,
		REG_NUM1_FOUR  = 3'd3,
		REG_FB_ONE     = 3'd4,
		REG_FB_TWO     = 3'd5,
		REG_OUT_SCALE  = 3'd6
	} gbc_reg_t;

	// Broadcast from the sequencer to every section.
	typedef struct packed {
		logic       clr;
		logic       mul_en;
		logic [2:0] mul_step;
	} gbc_ctrl_t;

	// Status of a section or of the output scaler.
	typedef struct packed {
		logic busy;
		logic done;
	} gbc_stat_t;

	function automatic logic [STATE_W-1:0] mag64(input logic signed [STATE_W-1:0] v);
		return v[STATE_W-1] ? STATE_W'(-v) : STATE_W'(v);
	endfunction

	function automatic logic [COEF_W-1:0] mag32(input logic signed [COEF_W-1:0] v);
		return v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
	endfunction

	function automatic logic signed [STATE_W-1:0] to_state(
		input logic signed [SAMPLE_BITS-1:0] s);
		logic signed [STATE_W-1:0] v;
		v = STATE_W'(s);
		return (v <<< TO_STATE_SHL) >>> TO_STATE_SHR;
	endfunction

	// a + m or a - m, clamped to the signed 64 bit range.
	function automatic logic signed [STATE_W-1:0] sat_op(
		input logic signed [STATE_W-1:0] a,
		input logic [STATE_W-2:0]        m,
		input logic                      sub);
		logic signed [STATE_W:0] s;
		s = sub ? ({a[STATE_W-1], a} - {2'b00, m}) : ({a[STATE_W-1], a} + {2'b00, m});
		if (s[STATE_W] != s[STATE_W-1])
			return s[STATE_W] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
		return s[STATE_W-1:0];
	endfunction

endpackage

// File: design/gbc_cell.sv
// One second-order section of the cascade: history, one shared 32x32 multiplier
// and a saturating adder that ripples the section output to its neighbor.
// Depends on gbc_pkg and gammatone_biquad_cascade_macros.svh.
`include "gammatone_biquad_cascade_macros.svh"

module gbc_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbc_pkg::gbc_ctrl_t                  ctrl,
	input  logic signed [gbc_pkg::COEF_W-1:0]   num1,
	input  logic signed [gbc_pkg::COEF_W-1:0]   fb1,
	input  logic signed [gbc_pkg::COEF_W-1:0]   fb2,
	input  logic signed [gbc_pkg::STATE_W-1:0]  x_prev,
	input  logic signed [gbc_pkg::STATE_W-1:0]  y_in,
	input  logic                                go,
	output logic signed [gbc_pkg::STATE_W-1:0]  y_out,
	output gbc_pkg::gbc_stat_t                  stat
);
	import gbc_pkg::*;

	localparam int HI_SH = COEF_W - COEF_FRAC;   // weight of the high partial product
	localparam int LO_W  = STATE_W - COEF_FRAC;

	logic signed [STATE_W-1:0] y1_q, y2_q, acc_q;
	logic [1:0]                mul_idx;
	logic                      mul_hi;
	logic signed [STATE_W-1:0] op_s;
	logic signed [COEF_W-1:0]  op_c;
	logic [STATE_W-1:0]        op_ms;
	logic [COEF_W-1:0]         op_mc, op_a;
	logic [STATE_W-1:0]        mul_p;

	logic [STATE_W-1:0]        prod_s1;
	logic                      vld_s1, hi_s1, neg_s1;
	logic [1:0]                idx_s1;

	logic [LO_W-1:0]           lo_q;
	logic [STATE_W-2:0]        mag_q [3];
	logic [2:0]                sub_q;
	logic [STATE_W-1:0]        lo_rnd;
	logic [STATE_W:0]          rnd_sum;
	logic [STATE_W-2:0]        rnd_mag;

	logic [1:0]                cph_q;
	logic                      done_q;
	logic [1:0]                add_idx;
	logic signed [STATE_W-1:0] add_a, add_res;

	// operand select for the partial products
	assign mul_idx = ctrl.mul_step[2:1];
	assign mul_hi  = ctrl.mul_step[0];

	always_comb begin
		unique case (mul_idx)
			2'd0: begin
				op_s = x_prev;
				op_c = num1;
			end
			2'd1: begin
				op_s = y1_q;
				op_c = fb1;
			end
			default: begin
				op_s = y2_q;
				op_c = fb2;
			end
		endcase
	end

	assign op_ms = mag64(op_s);
	assign op_mc = mag32(op_c);
	assign op_a  = mul_hi ? op_ms[STATE_W-1:COEF_W] : op_ms[COEF_W-1:0];
	assign mul_p = STATE_W'(op_a) * STATE_W'(op_mc);

	// round half up on the low part, then fold in the high part and clamp
	assign lo_rnd  = prod_s1 + (STATE_W'(1) << (COEF_FRAC - 1));
	assign rnd_sum = {2'b00, prod_s1[STATE_W-2-HI_SH:0], {HI_SH{1'b0}}} +
	                 (STATE_W + 1)'(lo_q);
	assign rnd_mag = ((|prod_s1[STATE_W-1:STATE_W-1-HI_SH]) || (|rnd_sum[STATE_W:STATE_W-1]))
	                 ? '1 : rnd_sum[STATE_W-2:0];

	// one saturating add per cycle: numerator term, then the two feedback terms
	always_comb begin
		priority if (go)
			add_idx = 2'd0;
		else if (cph_q[0])
			add_idx = 2'd1;
		else
			add_idx = 2'd2;
	end

	assign add_a   = go ? y_in : acc_q;
	assign add_res = sat_op(add_a, mag_q[add_idx], sub_q[add_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cph_q  <= '0;
			done_q <= 1'b0;
			y1_q   <= '0;
			y2_q   <= '0;
		end else begin
			vld_s1 <= ctrl.mul_en;
			cph_q  <= {cph_q[0], go};
			done_q <= cph_q[1];
			if (ctrl.clr) begin
				y1_q <= '0;
				y2_q <= '0;
			end else if (cph_q[1]) begin
				y2_q <= y1_q;
				y1_q <= add_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= mul_p;
			hi_s1   <= mul_hi;
			idx_s1  <= mul_idx;
			neg_s1  <= op_s[STATE_W-1] ^ op_c[COEF_W-1];
		end
		if (vld_s1 && !hi_s1)
			lo_q <= lo_rnd[STATE_W-1:COEF_FRAC];
		if (vld_s1 && hi_s1) begin
			mag_q[idx_s1] <= rnd_mag;
			// numerator term is added, feedback terms are subtracted
			sub_q[idx_s1] <= (idx_s1 == 2'd0) ? neg_s1 : !neg_s1;
		end
		if (go || cph_q[0])
			acc_q <= add_res;
	end

	assign y_out     = y1_q;
	assign stat.busy = |cph_q;
	assign stat.done = done_q;

	`GBC_ASSERT_IMPL(a_go_idle, go, !(|cph_q))
	`GBC_ASSERT_IMPL(a_go_done, go, ##3 done_q)
	`GBC_ASSERT_IMPL(a_mul_quiet, ctrl.mul_en, !(|cph_q) && !go)

endmodule

// File: design/gbc_scale.sv
// Output scaler: |y| times the output scale in two 32x32 steps, rounding and
// saturation to the 15 bit magnitude. Depends on gbc_pkg.
module gbc_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic signed [gbc_pkg::STATE_W-1:0]  y,
	input  logic [gbc_pkg::COEF_W-1:0]          scale,
	output logic [gbc_pkg::MAG_W-1:0]           result,
	output gbc_pkg::gbc_stat_t                  stat
);
	import gbc_pkg::*;

	localparam int Q_W = STATE_W - STATE_FRAC_BITS - 1;

	logic [STATE_W-1:0] m;
	logic [COEF_W-1:0]  mul_a;
	logic [STATE_W-1:0] mul_p;
	logic [STATE_W-1:0] prod_s1;
	logic [COEF_W-1:0]  lo_q;
	logic [STATE_W-1:0] up;
	logic [Q_W-1:0]     q;
	logic               ph_q, fin_q, done_q;
	logic [MAG_W-1:0]   result_q;

	assign m     = mag64(y);
	assign mul_a = ph_q ? m[STATE_W-1:COEF_W] : m[COEF_W-1:0];
	assign mul_p = STATE_W'(mul_a) * STATE_W'(scale);
	assign up    = prod_s1 + STATE_W'(lo_q) + (STATE_W'(1) << STATE_FRAC_BITS);
	assign q     = up[STATE_W-1:STATE_FRAC_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ph_q   <= go;
			fin_q  <= ph_q;
			done_q <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (go || ph_q)
			prod_s1 <= mul_p;
		if (ph_q)
			lo_q <= prod_s1[STATE_W-1:COEF_W];
		if (fin_q)
			result_q <= (|q[Q_W-1:MAG_W]) ? MAG_MAX : q[MAG_W-1:0];
	end

	assign result    = result_q;
	assign stat.busy = ph_q | fin_q;
	assign stat.done = done_q;

endmodule

// File: design/gammatone_biquad_cascade.sv
// Top level of one gammatone channel: four biquad sections in a chain, sequencer,
// configuration registers, input history and output register.
// Depends on gbc_pkg, gbc_cell, gbc_scale and gammatone_biquad_cascade_macros.svh.
//
//   channel   dir  signals                          payload
//   s_*       in   s_tvalid s_tready s_tdata s_tuser sample, block_start
//   m_*       out  m_tvalid m_tready m_tdata         magnitude
//   cfg_*     in   cfg_we cfg_index cfg_data         register writes
//
// A filtered sample occupies the block from acceptance until its result is in the
// output register: the six partial products each section runs on its own 32x32
// multiplier, the saturating-add ripple through the four sections, then output
// scaling and load. A warm-up sample skips these steps and loads a zero result
// into the output register. Input is taken only when the sequencer is idle; a
// result held by m_tready low stalls the sequencer before the output load.
// Reset clears coefficients, histories and the warm-up count at once.
`include "gammatone_biquad_cascade_macros.svh"

module gammatone_biquad_cascade (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [gbc_pkg::S_TDATA_W-1:0]        s_tdata,   // [15:0] sample
	input  logic                                 s_tuser,   // [0] block_start
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [gbc_pkg::M_TDATA_W-1:0]        m_tdata,   // [14:0] magnitude, [15] zero
	input  logic                                 cfg_we,
	input  logic [gbc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gbc_pkg::COEF_W-1:0]           cfg_data
);
	import gbc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_CHAIN = 5'b00100,
		ST_SCALE = 5'b01000,
		ST_DONE  = 5'b10000
	} gbc_state_t;

	gbc_state_t                  state_q, state_d;
	logic [2:0]                  cnt_q;
	logic                        go0_q;
	logic [1:0]                  warm_q, warm_eff;
	logic                        is_warm, accept, out_free;
	logic signed [SAMPLE_BITS-1:0] hist_q, prev_q, cur_q;
	logic [MAG_W-1:0]            res_q;
	logic                        m_tvalid_q;
	logic [M_TDATA_W-1:0]        m_tdata_q;

	logic signed [COEF_W-1:0]    num1_q [NUM_STAGES];
	logic signed [COEF_W-1:0]    fb1_q, fb2_q;
	logic [COEF_W-1:0]           oscale_q;

	gbc_ctrl_t                   ctrl;
	gbc_stat_t                   cell_stat [NUM_STAGES];
	gbc_stat_t                   scl_stat;
	logic [NUM_STAGES-1:0]       cell_busy;
	logic [NUM_STAGES-1:0]       cell_go;
	logic signed [STATE_W-1:0]   cell_yin   [NUM_STAGES];
	logic signed [STATE_W-1:0]   cell_xprev [NUM_STAGES];
	logic signed [STATE_W-1:0]   cell_yout  [NUM_STAGES];
	logic [MAG_W-1:0]            scl_result;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign warm_eff = s_tuser ? 2'd0 : warm_q;
	assign is_warm  = (warm_eff < WARMUP_LEN);
	assign out_free = !m_tvalid_q || m_tready;

	assign ctrl.clr      = accept && s_tuser;
	assign ctrl.mul_en   = (state_q == ST_MUL) && (cnt_q < MUL_STEPS);
	assign ctrl.mul_step = cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = is_warm ? ST_DONE : ST_MUL;
			ST_MUL:   if (cnt_q == MUL_STEPS) state_d = ST_CHAIN;
			ST_CHAIN: if (cell_stat[NUM_STAGES-1].done) state_d = ST_SCALE;
			ST_SCALE: if (scl_stat.done) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			go0_q      <= 1'b0;
			warm_q     <= '0;
			hist_q     <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_STAGES; i++)
				num1_q[i] <= '0;
			fb1_q      <= '0;
			fb2_q      <= '0;
			oscale_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == ST_MUL) ? cnt_q + 3'd1 : 3'd0;
			go0_q   <= (state_q == ST_MUL) && (cnt_q == MUL_STEPS);
			if (accept) begin
				warm_q <= is_warm ? warm_eff + 2'd1 : warm_eff;
				hist_q <= s_tdata;
			end
			if (state_q == ST_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (cfg_we) begin
				unique case (gbc_reg_t'(cfg_index))
					REG_NUM1_ONE:   num1_q[0] <= cfg_data;
					REG_NUM1_TWO:   num1_q[1] <= cfg_data;
					REG_NUM1_THREE: num1_q[2] <= cfg_data;
					REG_NUM1_FOUR:  num1_q[3] <= cfg_data;
					REG_FB_ONE:     fb1_q     <= cfg_data;
					REG_FB_TWO:     fb2_q     <= cfg_data;
					REG_OUT_SCALE:  oscale_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= s_tdata;
			prev_q <= hist_q;
		end
		if (accept && is_warm)
			res_q <= '0;
		else if (scl_stat.done)
			res_q <= scl_result;
		if (state_q == ST_DONE && out_free)
			m_tdata_q <= M_TDATA_W'(res_q);
	end

	// section chain: each section hands its new output to the next
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign cell_yin[k]   = to_state(cur_q);
			assign cell_xprev[k] = to_state(prev_q);
			assign cell_go[k]    = go0_q;
		end else begin : g_link
			assign cell_yin[k]   = cell_yout[k-1];
			assign cell_xprev[k] = cell_yout[k-1];
			assign cell_go[k]    = cell_stat[k-1].done;
		end

		gbc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.num1   (num1_q[k]),
			.fb1    (fb1_q),
			.fb2    (fb2_q),
			.x_prev (cell_xprev[k]),
			.y_in   (cell_yin[k]),
			.go     (cell_go[k]),
			.y_out  (cell_yout[k]),
			.stat   (cell_stat[k])
		);

		assign cell_busy[k] = cell_stat[k].busy;
	end

	gbc_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cell_stat[NUM_STAGES-1].done),
		.y      (cell_yout[NUM_STAGES-1]),
		.scale  (oscale_q),
		.result (scl_result),
		.stat   (scl_stat)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`GBC_ASSERT_NEXT(a_warm_short, accept && is_warm, state_q == ST_DONE)
	`GBC_ASSERT(a_one_cell, $onehot0(cell_busy))
	`GBC_ASSERT_NEXT(a_result_load, state_q == ST_DONE && out_free, m_tvalid && state_q == ST_IDLE)

endmodule

// File: sim/gammatone_biquad_cascade_tb.sv
// Self-checking testbench for the gammatone_biquad_cascade channel filter.
// Needs gbc_pkg and the gammatone_biquad_cascade RTL; predicts each magnitude
// in place and compares it with the output stream under random flow control.
`timescale 1ns / 1ps

module gammatone_biquad_cascade_tb;
	import gbc_pkg::*;

	typedef logic signed [STATE_W-1:0] state_t;
	typedef logic signed [COEF_W-1:0]  coef_t;

	localparam int SAMPLE_SHIFT     = STATE_FRAC_BITS - (SAMPLE_BITS - 1);
	localparam int OUT_SHIFT        = STATE_FRAC_BITS + 33;
	localparam int DRAIN_CYCLES     = 40;
	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int CONFIGS_PER_MODE = 3;
	localparam int ITEMS_PER_CONFIG = 104;
	localparam logic [CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [15:0] sample
	logic                   s_tuser   = 1'b0; // [0] block_start
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;          // [14:0] magnitude, [15] zero
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [COEF_W-1:0]      cfg_data  = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count = 0;
	int stalled_cycles = 0;

	logic [MAG_W-1:0] pending_magnitudes [$];

	// Filter model state and coefficient copies
	coef_t            gain_tap [NUM_STAGES] = '{default: '0};
	coef_t            pole_b1 = '0;
	coef_t            pole_b2 = '0;
	logic [COEF_W-1:0] out_scale_reg = '0;
	logic signed [SAMPLE_BITS-1:0] prev_audio [2] = '{default: '0};
	state_t           section_state [2*NUM_STAGES] = '{default: '0};
	logic [1:0]       warm_count = '0;

	gammatone_biquad_cascade DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// round(s * c / 2^28) half away from zero; magnitude clamps to max positive
	function automatic state_t coef_product(state_t s, coef_t c);
		logic [STATE_W-1:0] ms;
		logic [COEF_W-1:0]  mc;
		logic [127:0]       p;
		logic [STATE_W-1:0] r;
		ms = s[STATE_W-1] ? -s : s;
		mc = c[COEF_W-1] ? -c : c;
		p = 128'(ms) * 128'(mc);
		p = (p + (128'd1 << (COEF_FRAC - 1))) >> COEF_FRAC;
		r = (p > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : p[STATE_W-1:0];
		return (s[STATE_W-1] ^ c[COEF_W-1]) ? -r : r;
	endfunction

	function automatic state_t clamp_sum(state_t a, state_t b, logic minus);
		logic [STATE_W:0] t;
		t = minus ? ({a[STATE_W-1], a} - {b[STATE_W-1], b})
			: ({a[STATE_W-1], a} + {b[STATE_W-1], b});
		if (t[STATE_W] != t[STATE_W-1])
			return t[STATE_W] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
		return t[STATE_W-1:0];
	endfunction

	function automatic state_t to_state_format(logic signed [SAMPLE_BITS-1:0] a);
		state_t v;
		v = a;
		return v <<< SAMPLE_SHIFT;
	endfunction

	function automatic logic [MAG_W-1:0] scaled_magnitude(state_t y);
		logic [STATE_W-1:0] m;
		logic [127:0]       p;
		m = y[STATE_W-1] ? -y : y;
		p = 128'(m) * 128'(out_scale_reg);
		p = (p + (128'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
		return (p > 128'd32767) ? MAG_MAX : p[MAG_W-1:0];
	endfunction

	// Advances the filter model by one sample and returns its magnitude
	function automatic logic [MAG_W-1:0] filter_step(logic signed [SAMPLE_BITS-1:0] audio,
		logic first_of_block);
		state_t x_cur, x_prev, y, y1, y2;
		int k;
		if (first_of_block) begin
			prev_audio = '{default: '0};
			section_state = '{default: '0};
			warm_count = '0;
		end
		if (warm_count < WARMUP_LEN) begin
			prev_audio[1] = prev_audio[0];
			prev_audio[0] = audio;
			warm_count = warm_count + 1'b1;
			return '0;
		end
		x_cur = to_state_format(audio);
		x_prev = to_state_format(prev_audio[0]);
		prev_audio[1] = prev_audio[0];
		prev_audio[0] = audio;
		for (k = 0; k < NUM_STAGES; k++) begin
			y1 = section_state[2*k];
			y2 = section_state[2*k+1];
			y = clamp_sum(x_cur, coef_product(x_prev, gain_tap[k]), 1'b0);
			y = clamp_sum(y, coef_product(y1, pole_b1), 1'b1);
			y = clamp_sum(y, coef_product(y2, pole_b2), 1'b1);
			section_state[2*k+1] = y1;
			section_state[2*k] = y;
			x_cur = y;
			x_prev = y1;
		end
		return scaled_magnitude(x_cur);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_audio();
		case ($urandom_range(3))
			0: return SAMPLE_BITS'($urandom_range(511) - 256);
			1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] stable_tap();
		return $urandom_range(32'h2000_0000) - 32'h1000_0000;
	endfunction

	// All tasks below start and end at a falling edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_NUM1_ONE:   gain_tap[0] = value;
			REG_NUM1_TWO:   gain_tap[1] = value;
			REG_NUM1_THREE: gain_tap[2] = value;
			REG_NUM1_FOUR:  gain_tap[3] = value;
			REG_FB_ONE:     pole_b1 = value;
			REG_FB_TWO:     pole_b2 = value;
			REG_OUT_SCALE:  out_scale_reg = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_registers(input logic [COEF_W-1:0] t1, t2, t3, t4, b1, b2, scale);
		write_reg(REG_NUM1_ONE, t1);
		write_reg(REG_NUM1_TWO, t2);
		write_reg(REG_NUM1_THREE, t3);
		write_reg(REG_NUM1_FOUR, t4);
		write_reg(REG_FB_ONE, b1);
		write_reg(REG_FB_TWO, b2);
		write_reg(REG_OUT_SCALE, scale);
	endtask

	// tvalid is left high after a transaction so back-to-back items need no extra NBA
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] audio,
		input logic first_of_block);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= audio;
		s_tuser <= first_of_block;
		do @(posedge clk); while (!s_tready);
		pending_magnitudes.push_back(filter_step(audio, first_of_block));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_magnitudes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Coefficients still at reset; warm-up without any block start
	task automatic test_reset_warmup();
		send_sample(16'sh4000, 1'b0);
		send_sample(16'shC000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		wait_drained();
	endtask

	task automatic test_directed_extremes();
		load_registers(32'h0800_0000, 32'hF800_0000, 32'h1000_0000, 32'hE000_0000,
			32'hE200_0000, 32'h0F00_0000, 32'h0004_0000);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'shFFFF, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'sh1234, 1'b1);
		// block start right after another one, then back into filtering
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shAAAA, 1'b0);
		wait_drained();
	endtask

	// Register extremes drive the states into 64-bit clamping
	task automatic test_overflow();
		int i;
		load_registers(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		write_reg(UNUSED_REG_IDX, 32'hFFFF_FFFF);
		send_sample(16'sh7FFF, 1'b1);
		for (i = 0; i < 5; i++)
			send_sample(16'sh7FFF, 1'b0);
		wait_drained();
		load_registers(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
		send_sample(16'sh8000, 1'b1);
		for (i = 0; i < 5; i++)
			send_sample(i[0] ? 16'sh7FFF : 16'sh8000, 1'b0);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int tx_idle, input int rx_idle);
		int cfg_round, n_sent, run_len, j;
		logic [COEF_W-1:0] b1_mag;
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		for (cfg_round = 0; cfg_round < CONFIGS_PER_MODE; cfg_round++) begin
			wait_drained();
			if (cfg_round == 0) begin
				// unconstrained coefficients, mostly unstable and clamping
				load_registers($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			end else begin
				// complex pole pair inside the unit circle
				b1_mag = $urandom_range(32'h1B33_3333, 32'h0800_0000);
				load_registers(stable_tap(), stable_tap(), stable_tap(), stable_tap(),
					$urandom_range(1) ? -b1_mag : b1_mag,
					$urandom_range(32'h0FFF_0000, 32'h0CCC_CCCC),
					$urandom >> $urandom_range(31));
			end
			n_sent = 0;
			while (n_sent < ITEMS_PER_CONFIG) begin
				if ($urandom_range(99) < 85) begin
					run_len = $urandom_range(60, 2);
					for (j = 0; j < run_len; j++)
						send_sample(random_audio(), j == 0);
				end else begin
					run_len = $urandom_range(4, 1);
					for (j = 0; j < run_len; j++)
						send_sample(random_audio(), 1'($urandom_range(1)));
				end
				n_sent += run_len;
			end
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : result_check
		logic [MAG_W-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_magnitudes.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, m_tdata[MAG_W-1:0]);
					mismatch_count++;
				end else begin
					want = pending_magnitudes.pop_front();
					if (m_tdata[MAG_W-1:0] !== want || m_tdata[M_TDATA_W-1] !== 1'b0) begin
						$display("%0t: magnitude mismatch, expected %0d, actual %0d (tdata %h)",
							$time, want, m_tdata[MAG_W-1:0], m_tdata);
						mismatch_count++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stalled_cycles = 0;
			else
				stalled_cycles = stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 7;
		recv_idle_pct = 80;
		test_reset_warmup();
		test_directed_extremes();
		test_overflow();
		test_random_traffic(7, 80);
		test_random_traffic(80, 7);
		test_random_traffic(0, 0);
		wait_drained();
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/gbc_pkg.sv
design/gbc_cell.sv
design/gbc_scale.sv
design/gammatone_biquad_cascade.sv
sim/gammatone_biquad_cascade_tb.sv
